@@ src/srtf_pkg.sv @@
// Shared constants and types for the SRTF tick scheduler.
package srtf_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int TIME_W   = 32;
    localparam int VAL_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int CFG_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

@@ src/srtf_tick_scheduler.sv @@
// Shortest-remaining-time-first scheduler over a table of process slots.
// Load word: writes the slot tables, no result. Tick word: one compare unit scans n = min(slot_count,
//   16) slots, one per cycle from a registered read; the result word becomes valid after the scan
//   and the update state, when s_tready returns; later only while the output register is held.
// Reset: synchronous, time 0, slot_count 1, finished marks clear, output empty, tables kept.
module srtf_tick_scheduler (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srtf_pkg::S_DATA_W-1:0]  s_tdata,   // slot_index[3:0], arrival_time[19:4],
                                                      // burst_length[35:20], zero fill
    input  logic [0:0]                     s_tuser,   // command[0]
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srtf_pkg::M_DATA_W-1:0]  m_tdata,   // time_now[31:0], chosen_slot[35:32],
                                                      // ran[36], slot_finished[37],
                                                      // all_done[38], zero fill
    // configuration: slot_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srtf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = srtf_pkg::IDX_W;
    localparam int CNT_W = srtf_pkg::CNT_W;
    localparam int VAL_W = srtf_pkg::VAL_W;

    // input fields
    logic [srtf_pkg::SLOT_W-1:0] in_slot;
    logic [VAL_W-1:0]            in_arrival;
    logic [VAL_W-1:0]            in_burst;
    logic                        in_cmd;

    assign in_slot    = s_tdata[3:0];
    assign in_arrival = s_tdata[19:4];
    assign in_burst   = s_tdata[35:20];
    assign in_cmd     = s_tuser[0];

    // slot tables
    logic [VAL_W-1:0] arrival_mem [srtf_pkg::SLOTS];
    logic [VAL_W-1:0] remain_mem  [srtf_pkg::SLOTS];

    srtf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;
    logic                          qv_reg, qv_next;
    logic [IDX_W-1:0]              qidx_reg;
    logic [VAL_W-1:0]              arr_q_reg, rem_q_reg;
    logic                          found_reg, found_next;
    logic                          seen_reg, seen_next;
    logic                          multi_reg, multi_next;
    logic [IDX_W-1:0]              best_idx_reg, best_idx_next;
    logic [VAL_W-1:0]              best_rem_reg, best_rem_next;
    logic [srtf_pkg::TIME_W-1:0]   time_reg, time_next;
    logic [srtf_pkg::CFG_W-1:0]    count_reg;
    logic [srtf_pkg::SLOTS-1:0]    fin_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [srtf_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [CNT_W-1:0] active_cnt;
    logic             accept;
    logic             load_ok;
    logic             arr_we, rem_we, fin_we, fin_val;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] rem_wdata;
    logic [IDX_W-1:0] raddr;
    logic             rd_en;
    logic             arrived, cand;
    logic [VAL_W-1:0] rem_dec;
    logic             tick_fin, tick_done, out_free;

    assign active_cnt = (32'(count_reg) < srtf_pkg::SLOTS) ? CNT_W'(count_reg)
                                                          : CNT_W'(srtf_pkg::SLOTS);
    assign s_tready  = (state_reg == srtf_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_ok   = (32'(in_slot) < srtf_pkg::SLOTS);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign raddr   = scan_reg[IDX_W-1:0];
    assign arrived = (32'(arr_q_reg) <= time_reg);
    assign cand    = !fin_reg[qidx_reg] && arrived;

    assign rem_dec   = (best_rem_reg != '0) ? (best_rem_reg - VAL_W'(1)) : '0;
    assign tick_fin  = found_reg && (rem_dec == '0);
    // only the chosen slot can change, and it was unfinished
    assign tick_done = !seen_reg || (!multi_reg && tick_fin);

    always_comb begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        qv_next       = 1'b0;
        found_next    = found_reg;
        seen_next     = seen_reg;
        multi_next    = multi_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        time_next     = time_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        arr_we        = 1'b0;
        rem_we        = 1'b0;
        fin_we        = 1'b0;
        fin_val       = 1'b0;
        waddr         = IDX_W'(in_slot);
        rem_wdata     = in_burst;

        // compare stage: data of the slot read last cycle
        if (qv_reg) begin
            if (cand && (!found_reg || (rem_q_reg < best_rem_reg))) begin
                found_next    = 1'b1;
                best_idx_next = qidx_reg;
                best_rem_next = rem_q_reg;
            end
            if (!fin_reg[qidx_reg]) begin
                seen_next  = 1'b1;
                multi_next = multi_reg || seen_reg;
            end
        end

        case (state_reg)
            srtf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == srtf_pkg::CMD_TICK) begin
                        scan_next  = '0;
                        found_next = 1'b0;
                        seen_next  = 1'b0;
                        multi_next = 1'b0;
                        state_next = srtf_pkg::ST_SCAN;
                    end else if (load_ok) begin
                        arr_we  = 1'b1;
                        rem_we  = 1'b1;
                        fin_we  = 1'b1;
                        fin_val = (in_burst == '0);
                    end
                end
            end
            srtf_pkg::ST_SCAN: begin
                if (scan_reg < active_cnt) begin
                    rd_en     = 1'b1;
                    qv_next   = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    state_next = srtf_pkg::ST_UPDATE;
                end
            end
            srtf_pkg::ST_UPDATE: begin
                if (out_free) begin
                    waddr     = best_idx_reg;
                    rem_wdata = rem_dec;
                    rem_we    = found_reg;
                    fin_we    = tick_fin;
                    fin_val   = 1'b1;
                    time_next = time_reg + srtf_pkg::TIME_W'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[31:0]  = time_reg;
                    m_data_next[35:32] = found_reg ? srtf_pkg::SLOT_W'(best_idx_reg)
                                                   : '0;
                    m_data_next[36]    = found_reg;
                    m_data_next[37]    = tick_fin;
                    m_data_next[38]    = tick_done;
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srtf_pkg::ST_IDLE;
            scan_reg    <= '0;
            qv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            multi_reg   <= 1'b0;
            time_reg    <= '0;
            count_reg   <= srtf_pkg::CFG_W'(1);
            fin_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            qv_reg      <= qv_next;
            found_reg   <= found_next;
            seen_reg    <= seen_next;
            multi_reg   <= multi_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (fin_we) begin
                fin_reg[waddr] <= fin_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        m_data_reg   <= m_data_next;
    end

    // slot tables: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (arr_we) begin
            arrival_mem[waddr] <= in_arrival;
        end
        if (rem_we) begin
            remain_mem[waddr] <= rem_wdata;
        end
        if (rd_en) begin
            arr_q_reg <= arrival_mem[raddr];
            rem_q_reg <= remain_mem[raddr];
            qidx_reg  <= raddr;
        end
    end

endmodule

@@ src/srtf_checker.sv @@
// Port-level checker for the SRTF tick scheduler, bound to the top level.
module srtf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srtf_pkg::M_DATA_W-1:0]  m_tdata
);

    // a tick word keeps the block busy for the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == srtf_pkg::CMD_TICK)) |=> !s_tready)
        else $error("ready high right after a tick word");

    // an idle tick names slot zero and cannot finish anything
    a_idle_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[36]) |-> ((m_tdata[35:32] == '0) && !m_tdata[37]))
        else $error("idle tick word carries a slot or a finish");

    // a word is produced only by a tick word taken earlier
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(!s_tready))
        else $error("result word without a tick in progress");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

endmodule

bind srtf_tick_scheduler srtf_checker u_srtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
